// ===== sv/hsvc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, widths and request types for the HSV to RGB converter.
// No dependencies; every other file imports this package.
package hsvc_pkg;

    // Number formats
    localparam int HUE_FRAC_BITS  = 6;
    localparam int COMPONENT_BITS = 8;
    localparam int HUE_W          = 16;
    localparam int SEC_W          = 3;

    localparam int COMP_MAX       = (1 << COMPONENT_BITS) - 1;
    localparam int SECTOR_UNITS   = 60 << HUE_FRAC_BITS;
    localparam int TURN_UNITS     = 6 * SECTOR_UNITS;

    // Fraction within a sector, s*r products, full numerators
    localparam int FRAC_W = $clog2(SECTOR_UNITS);
    localparam int SR_W   = COMPONENT_BITS + FRAC_W;
    localparam int NUM_W  = COMPONENT_BITS + SR_W;
    localparam int PM_W   = 2 * COMPONENT_BITS;

    // Divisor of q and t: one full code times one sector
    localparam longint DEN = longint'(COMP_MAX) * longint'(SECTOR_UNITS);

    // Floor reciprocals; estimate is the true quotient or one below
    localparam longint KD   = (longint'(1) << NUM_W) / DEN;
    localparam int     KD_W = NUM_W - $clog2(DEN) + 1;
    localparam longint KM   = (longint'(1) << PM_W) / COMP_MAX;
    localparam int     KM_W = PM_W - COMPONENT_BITS + 1;

    typedef logic [COMPONENT_BITS-1:0] t_comp;
    typedef logic [SEC_W-1:0]          t_sector;

    // Sector split of one pixel
    typedef struct packed {
        t_sector           sector;
        logic [FRAC_W-1:0] frac;
        t_comp             sat;
        t_comp             val;
    } t_sec_req;

    // Numerators of p, q and t before division
    typedef struct packed {
        t_sector          sector;
        t_comp            val;
        logic [PM_W-1:0]  px;
        logic [NUM_W-1:0] qx;
        logic [NUM_W-1:0] tx;
    } t_num_req;

    // Finished components ahead of routing
    typedef struct packed {
        t_sector sector;
        t_comp   val;
        t_comp   p;
        t_comp   q;
        t_comp   t;
    } t_pqt_req;

    // Output pixel, blue in the low bits
    typedef struct packed {
        t_comp red;
        t_comp green;
        t_comp blue;
    } t_rgb;

endpackage

// ===== sv/hsvc_sector.sv =====
`timescale 1ns / 1ps
// First pipeline stage: hue wrap, sector number and fraction within the sector.
// Depends on hsvc_pkg.
module hsvc_sector
    import hsvc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [HUE_W-1:0]  i_hue,
    input  t_comp             i_sat,
    input  t_comp             i_val,
    output logic              o_valid,
    input  logic              i_ready,
    output t_sec_req          o_req
);

    logic             hue_ovr;
    logic [HUE_W-1:0] hue_w;
    t_sector          sec;
    t_sec_req         n_req;
    t_sec_req         r_req;
    logic             r_valid;
    logic             ld;

    // A full turn or more counts as zero
    assign hue_ovr = 32'(i_hue) >= 32'(TURN_UNITS);
    assign hue_w   = hue_ovr ? '0 : i_hue;

    // Sector from five parallel threshold compares, fraction by subtraction
    always_comb begin
        sec = '0;
        for (int k = 1; k < 6; k++) begin
            if (32'(hue_w) >= 32'(k * SECTOR_UNITS)) begin
                sec = sec + t_sector'(1);
            end
        end
        n_req.sector = sec;
        n_req.frac   = FRAC_W'(32'(hue_w) - 32'(sec) * 32'(SECTOR_UNITS));
        n_req.sat    = i_sat;
        n_req.val    = i_val;
    end

    assign ld      = !r_valid || i_ready;
    assign o_ready = ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ===== sv/hsvc_products.sv =====
`timescale 1ns / 1ps
// Two stages forming the numerators v(M-s), v(MW-s*r) and v(MW-s(W-r)).
// Depends on hsvc_pkg.
module hsvc_products
    import hsvc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_sec_req i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_num_req o_req
);

    // Stage A registers
    logic              r_va;
    t_sector           r_a_sector;
    t_comp             r_a_val;
    logic [SR_W-1:0]   r_a_sr;
    logic [SR_W-1:0]   r_a_sw;
    logic [PM_W-1:0]   r_a_pm;
    // Stage B registers
    logic              r_vb;
    t_num_req          r_b;

    logic              ld_a;
    logic              ld_b;
    logic [FRAC_W-1:0] frac_c;
    t_comp             sat_c;
    logic [SR_W-1:0]   n_sr;
    logic [SR_W-1:0]   n_sw;
    logic [PM_W-1:0]   n_pm;
    t_num_req          n_b;

    assign ld_b    = !r_vb || i_ready;
    assign ld_a    = !r_va || ld_b;
    assign o_ready = ld_a;

    // Stage A: s*r, s*(W-r) and v*(M-s)
    always_comb begin
        frac_c = FRAC_W'(SECTOR_UNITS) - i_req.frac;
        sat_c  = t_comp'(COMP_MAX) - i_req.sat;
        n_sr   = SR_W'(i_req.sat) * SR_W'(i_req.frac);
        n_sw   = SR_W'(i_req.sat) * SR_W'(frac_c);
        n_pm   = PM_W'(i_req.val) * PM_W'(sat_c);
    end

    // Stage B: scale the complements by v
    always_comb begin
        n_b.sector = r_a_sector;
        n_b.val    = r_a_val;
        n_b.px     = r_a_pm;
        n_b.qx     = NUM_W'(r_a_val) * NUM_W'(SR_W'(DEN) - r_a_sr);
        n_b.tx     = NUM_W'(r_a_val) * NUM_W'(SR_W'(DEN) - r_a_sw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (ld_a) begin
                r_va <= i_valid;
            end
            if (ld_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_a_sector <= i_req.sector;
            r_a_val    <= i_req.val;
            r_a_sr     <= n_sr;
            r_a_sw     <= n_sw;
            r_a_pm     <= n_pm;
        end
        if (ld_b) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_vb;
    assign o_req   = r_b;

endmodule

// ===== sv/hsvc_divide.sv =====
`timescale 1ns / 1ps
// Three-stage constant division of p, q and t numerators: reciprocal estimate,
// back product, then a single remainder correction. Depends on hsvc_pkg.
module hsvc_divide
    import hsvc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_num_req i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_pqt_req o_req
);

    localparam int PE_W = PM_W + KM_W;
    localparam int QE_W = NUM_W + KD_W;

    // Stage A: numerators and quotient estimates
    logic             r_va;
    t_num_req         r_a;
    t_comp            r_a_pe;
    t_comp            r_a_qe;
    t_comp            r_a_te;
    // Stage B: numerators, estimates and back products
    logic             r_vb;
    t_num_req         r_b;
    t_comp            r_b_pe;
    t_comp            r_b_qe;
    t_comp            r_b_te;
    logic [PM_W-1:0]  r_b_pb;
    logic [NUM_W-1:0] r_b_qb;
    logic [NUM_W-1:0] r_b_tb;
    // Stage C: corrected quotients
    logic             r_vc;
    t_pqt_req         r_c;

    logic             ld_a;
    logic             ld_b;
    logic             ld_c;
    logic [PE_W-1:0]  pm_full;
    logic [QE_W-1:0]  qm_full;
    logic [QE_W-1:0]  tm_full;
    logic [PM_W-1:0]  p_rem;
    logic [NUM_W-1:0] q_rem;
    logic [NUM_W-1:0] t_rem;
    t_pqt_req         n_c;

    assign ld_c    = !r_vc || i_ready;
    assign ld_b    = !r_vb || ld_c;
    assign ld_a    = !r_va || ld_b;
    assign o_ready = ld_a;

    // Stage A: multiply by floor reciprocal, keep the high part
    always_comb begin
        pm_full = PE_W'(i_req.px) * PE_W'(KM);
        qm_full = QE_W'(i_req.qx) * QE_W'(KD);
        tm_full = QE_W'(i_req.tx) * QE_W'(KD);
    end

    // Stage C: estimate is low by at most one
    always_comb begin
        p_rem      = r_b.px - r_b_pb;
        q_rem      = r_b.qx - r_b_qb;
        t_rem      = r_b.tx - r_b_tb;
        n_c.sector = r_b.sector;
        n_c.val    = r_b.val;
        n_c.p      = (p_rem >= PM_W'(COMP_MAX)) ? r_b_pe + t_comp'(1) : r_b_pe;
        n_c.q      = (q_rem >= NUM_W'(DEN)) ? r_b_qe + t_comp'(1) : r_b_qe;
        n_c.t      = (t_rem >= NUM_W'(DEN)) ? r_b_te + t_comp'(1) : r_b_te;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (ld_a) begin
                r_va <= i_valid;
            end
            if (ld_b) begin
                r_vb <= r_va;
            end
            if (ld_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_a    <= i_req;
            r_a_pe <= pm_full[PM_W +: COMPONENT_BITS];
            r_a_qe <= qm_full[NUM_W +: COMPONENT_BITS];
            r_a_te <= tm_full[NUM_W +: COMPONENT_BITS];
        end
        // Stage B: back products of the estimates
        if (ld_b) begin
            r_b    <= r_a;
            r_b_pe <= r_a_pe;
            r_b_qe <= r_a_qe;
            r_b_te <= r_a_te;
            r_b_pb <= PM_W'(r_a_pe) * PM_W'(COMP_MAX);
            r_b_qb <= NUM_W'(r_a_qe) * NUM_W'(DEN);
            r_b_tb <= NUM_W'(r_a_te) * NUM_W'(DEN);
        end
        if (ld_c) begin
            r_c <= n_c;
        end
    end

    assign o_valid = r_vc;
    assign o_req   = r_c;

    // Reciprocal estimates must be within one of the true quotient
    a_p_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> (p_rem < PM_W'(2 * COMP_MAX)))
        else $error("p remainder out of correction range");
    a_q_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> (q_rem < NUM_W'(2 * DEN)))
        else $error("q remainder out of correction range");
    a_t_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> (t_rem < NUM_W'(2 * DEN)))
        else $error("t remainder out of correction range");

endmodule

// ===== sv/hsvc_route.sv =====
`timescale 1ns / 1ps
// Final stage: six-way routing of v, p, q and t into the output register.
// Depends on hsvc_pkg.
module hsvc_route
    import hsvc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_pqt_req i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_rgb     o_rgb
);

    logic r_valid;
    t_rgb r_rgb;
    t_rgb n_rgb;
    logic ld;

    // Component order per sector
    always_comb begin
        case (i_req.sector)
            t_sector'(0): begin
                n_rgb.red = i_req.val; n_rgb.green = i_req.t;   n_rgb.blue = i_req.p;
            end
            t_sector'(1): begin
                n_rgb.red = i_req.q;   n_rgb.green = i_req.val; n_rgb.blue = i_req.p;
            end
            t_sector'(2): begin
                n_rgb.red = i_req.p;   n_rgb.green = i_req.val; n_rgb.blue = i_req.t;
            end
            t_sector'(3): begin
                n_rgb.red = i_req.p;   n_rgb.green = i_req.q;   n_rgb.blue = i_req.val;
            end
            t_sector'(4): begin
                n_rgb.red = i_req.t;   n_rgb.green = i_req.p;   n_rgb.blue = i_req.val;
            end
            default: begin
                n_rgb.red = i_req.val; n_rgb.green = i_req.p;   n_rgb.blue = i_req.q;
            end
        endcase
    end

    assign ld      = !r_valid || i_ready;
    assign o_ready = ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// HSV to RGB pixel converter. Takes one pixel per clock and returns it as
// 8-bit blue, green and red through seven register stages (sector split, two
// product stages, three division stages, routing); since every stage is a
// plain pipeline register the rate is one pixel per clock for as long as the
// output side keeps taking requests. A stall on the output fills empty stages
// first and only then pushes back on the input. Hue is in 1/64 degree units
// and any hue of 360 degrees or more acts as zero; each component is the exact
// result truncated to 0..255.
// Depends on hsvc_pkg, hsvc_sector, hsvc_products, hsvc_divide, hsvc_route.
module hsv_to_rgb_converter
    import hsvc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // blue[7:0], green[15:8], red[23:16]
);

    logic     sec_valid;
    logic     sec_ready;
    t_sec_req sec_req;
    logic     num_valid;
    logic     num_ready;
    t_num_req num_req;
    logic     pqt_valid;
    logic     pqt_ready;
    t_pqt_req pqt_req;
    t_rgb     rgb;

    // Sector split
    hsvc_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_hue   (s_axis_tdata[15:0]),
        .i_sat   (s_axis_tdata[23:16]),
        .i_val   (s_axis_tdata[31:24]),
        .o_valid (sec_valid),
        .i_ready (sec_ready),
        .o_req   (sec_req)
    );

    // Numerators
    hsvc_products u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sec_valid),
        .o_ready (sec_ready),
        .i_req   (sec_req),
        .o_valid (num_valid),
        .i_ready (num_ready),
        .o_req   (num_req)
    );

    // Constant division
    hsvc_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (num_valid),
        .o_ready (num_ready),
        .i_req   (num_req),
        .o_valid (pqt_valid),
        .i_ready (pqt_ready),
        .o_req   (pqt_req)
    );

    // Routing and output register
    hsvc_route u_route (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pqt_valid),
        .o_ready (pqt_ready),
        .i_req   (pqt_req),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rgb   (rgb)
    );

    assign m_axis_tdata = rgb;

endmodule

// ===== tb/hsv_to_rgb_converter_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for hsv_to_rgb_converter: drives HSV pixel requests, predicts each
// blue/green/red result in integer arithmetic and checks the output stream in order.
// Depends on hsvc_pkg and the converter RTL.
module hsv_to_rgb_converter_test;
    import hsvc_pkg::*;

    // One sector of hue in 1/64 degree units, a full turn, full component code
    localparam longint unsigned SECTOR_SPAN = 60 * 64;
    localparam longint unsigned FULL_TURN   = 6 * SECTOR_SPAN;
    localparam longint unsigned CODE_MAX    = 255;
    localparam int              MAX_PRINTS  = 30;

    // Sixty-degree sectors of the colour wheel
    typedef enum logic [2:0] {
        SEC_RED_TO_YELLOW,
        SEC_YELLOW_TO_GREEN,
        SEC_GREEN_TO_CYAN,
        SEC_CYAN_TO_BLUE,
        SEC_BLUE_TO_MAGENTA,
        SEC_MAGENTA_TO_RED
    } t_hue_sector;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // hue[15:0], saturation[23:16], brightness[31:24]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // blue[7:0], green[15:8], red[23:16]

    t_rgb expected_rgb[$];
    int   n_sent       = 0;
    int   n_checked    = 0;
    int   n_mismatches = 0;
    bit   gaps_on      = 1'b0;
    int   hold_request = 0;
    int   hold_left    = 0;

    hsv_to_rgb_converter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Expected pixel: six-sector conversion, each component floored
    function automatic t_rgb hsv_pixel_to_rgb(input logic [15:0] hue, input logic [7:0] sat,
                                              input logic [7:0] val);
        longint unsigned h, s, v, frac, den, p, q, t;
        t_hue_sector     sector;
        t_rgb            rgb;
        h = 64'(hue);
        s = 64'(sat);
        v = 64'(val);
        if (s == 0) begin
            rgb.red   = val;
            rgb.green = val;
            rgb.blue  = val;
            return rgb;
        end
        if (h >= FULL_TURN) h = 0;
        sector = t_hue_sector'(h / SECTOR_SPAN);
        frac   = h % SECTOR_SPAN;
        den    = CODE_MAX * SECTOR_SPAN;
        p = (v * (CODE_MAX - s)) / CODE_MAX;
        q = (v * (den - s * frac)) / den;
        t = (v * (den - s * (SECTOR_SPAN - frac))) / den;
        case (sector)
            SEC_RED_TO_YELLOW: begin
                rgb.red = t_comp'(v); rgb.green = t_comp'(t); rgb.blue = t_comp'(p);
            end
            SEC_YELLOW_TO_GREEN: begin
                rgb.red = t_comp'(q); rgb.green = t_comp'(v); rgb.blue = t_comp'(p);
            end
            SEC_GREEN_TO_CYAN: begin
                rgb.red = t_comp'(p); rgb.green = t_comp'(v); rgb.blue = t_comp'(t);
            end
            SEC_CYAN_TO_BLUE: begin
                rgb.red = t_comp'(p); rgb.green = t_comp'(q); rgb.blue = t_comp'(v);
            end
            SEC_BLUE_TO_MAGENTA: begin
                rgb.red = t_comp'(t); rgb.green = t_comp'(p); rgb.blue = t_comp'(v);
            end
            default: begin
                rgb.red = t_comp'(v); rgb.green = t_comp'(p); rgb.blue = t_comp'(q);
            end
        endcase
        return rgb;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_mismatches++;
        if (n_mismatches <= MAX_PRINTS)
            $display("%0t ERROR result %0d: %s got %0d, want %0d", $time, n_checked, what,
                     got, want);
    endtask

    // One pixel request; optional idle cycles ahead of it, then wait for the handshake
    task automatic send_pixel(input logic [15:0] hue, input logic [7:0] sat,
                              input logic [7:0] val);
        int gap;
        gap = 0;
        while (gaps_on && $urandom_range(99) < 22) gap++;
        if (gap != 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, sat, hue};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_rgb.insert(expected_rgb.size(), hsv_pixel_to_rgb(hue, sat, val));
        n_sent++;
    endtask

    // Receiver: long hold-off on request, random stalls when gaps are on
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (gaps_on) begin
            m_axis_tready <= ($urandom_range(99) >= 22);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result checker, oldest expectation first
    always @(posedge i_clk) begin
        t_rgb got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_rgb'(m_axis_tdata);
            if (expected_rgb.size() == 0) begin
                report_mismatch("unexpected result, pixel", int'(got), 0);
            end else begin
                want = expected_rgb.pop_front();
                if (got.blue != want.blue)
                    report_mismatch("blue", int'(got.blue), int'(want.blue));
                if (got.green != want.green)
                    report_mismatch("green", int'(got.green), int'(want.green));
                if (got.red != want.red)
                    report_mismatch("red", int'(got.red), int'(want.red));
            end
            n_checked++;
        end
    end

    // Extremes, grey, hue wrap and every sector
    task automatic test_directed();
        gaps_on = 1'b0;
        send_pixel(16'd0, 8'd255, 8'd255);
        send_pixel(16'd0, 8'd0, 8'd0);
        send_pixel(16'd12345, 8'd0, 8'd255);
        send_pixel(16'hFFFF, 8'd0, 8'd128);
        send_pixel(16'd23040, 8'd255, 8'd200);
        send_pixel(16'hFFFF, 8'd200, 8'd255);
        send_pixel(16'd23039, 8'd255, 8'd255);
        send_pixel(16'd100, 8'd1, 8'd255);
        send_pixel(16'd7000, 8'd255, 8'd1);
        send_pixel(16'd15000, 8'd128, 8'd0);
        for (int k = 0; k < 6; k++)
            send_pixel(16'(k * SECTOR_SPAN + SECTOR_SPAN / 2), 8'd255, 8'd255);
        for (int k = 1; k < 6; k++)
            send_pixel(16'(k * SECTOR_SPAN), 8'd170, 8'd230);
    endtask

    function automatic logic [15:0] pick_hue();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'($urandom_range(FULL_TURN - 1));
        if (r < 85) return 16'($urandom_range(16'hFFFF, FULL_TURN));
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_component();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'd0;
        if (r < 20) return 8'd255;
        return 8'($urandom);
    endfunction

    task automatic test_random_pixels(input int count, input bit with_gaps);
        gaps_on = with_gaps;
        repeat (count) send_pixel(pick_hue(), pick_component(), pick_component());
    endtask

    // Output held off long enough to fill the pipe and push back on the input
    task automatic test_output_stall();
        gaps_on      = 1'b0;
        hold_request = 80;
        repeat (40) send_pixel(pick_hue(), pick_component(), pick_component());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_pixels(150, 1'b0);
        test_output_stall();
        test_random_pixels(540, 1'b1);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_rgb.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d pixels, checked %0d: grey, hue wrap, all six sectors and extremes,",
                 n_sent, n_checked);
        $display("with random gaps on both sides and one long output stall");
        if (n_mismatches == 0 && expected_rgb.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("Timeout with %0d results outstanding", expected_rgb.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
